// ----- hw/rtl/pccmg_pkg.sv -----
// Package for the partition cut-cost and move-gain evaluator.
// Holds field widths, item kind codes, pipeline types and the class clamp.
// No dependencies.
`default_nettype none

package pccmg_pkg;

   localparam int VERTEX_W         = 10;
   localparam int NUM_VERTICES     = 1024;
   localparam int CLASS_W          = 4;
   localparam int MAX_CLASSES      = 16;
   localparam int WEIGHT_W         = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int CUT_W            = 36;
   localparam int GAIN_W           = 37;

   localparam logic [1:0] KIND_SET_CLASS = 2'd0;
   localparam logic [1:0] KIND_CUT       = 2'd1;
   localparam logic [1:0] KIND_GAIN      = 2'd2;

   localparam logic RESULT_CUT  = 1'b0;
   localparam logic RESULT_GAIN = 1'b1;

   localparam logic [63:0] WEIGHT_MASK_WIDE = (64'd1 << WEIGHT_FRAC_BITS) - 64'd1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = WEIGHT_MASK_WIDE[WEIGHT_W-1:0];

   localparam logic [CUT_W-1:0]         CUT_MAX  = {CUT_W{1'b1}};
   localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

   // Entry carried alongside the class reads into the accumulate stage
   typedef struct packed {
      logic [1:0]          kind;
      logic [CLASS_W-1:0]  target_class;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } stage_type;

   // Write request into the class store
   typedef struct packed {
      logic                en;
      logic [VERTEX_W-1:0] addr;
      logic [CLASS_W-1:0]  data;
   } class_wr_type;

   function automatic logic [CLASS_W-1:0] clamp_class(input logic [CLASS_W-1:0] c);
      logic [CLASS_W-1:0] r;
      r = c;
      if (int'(c) > MAX_CLASSES - 1) begin
         r = CLASS_W'(MAX_CLASSES - 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pccmg_if.sv -----
// Request and response channel interfaces for the cut-cost evaluator.
// Valid/ready handshake with payload; depends on pccmg_pkg.
`default_nettype none

interface pccmg_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          kind;
   logic [pccmg_pkg::VERTEX_W-1:0]      vertex;
   logic [pccmg_pkg::VERTEX_W-1:0]      neighbor;
   logic [pccmg_pkg::CLASS_W-1:0]       vertex_class;
   logic [pccmg_pkg::CLASS_W-1:0]       target_class;
   logic [pccmg_pkg::WEIGHT_W-1:0]      weight;
   logic                                last;

   modport source (output valid, kind, vertex, neighbor, vertex_class, target_class,
                   weight, last, input ready);
   modport sink   (input valid, kind, vertex, neighbor, vertex_class, target_class,
                   weight, last, output ready);
endinterface

interface pccmg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                result_kind;
   logic [pccmg_pkg::CUT_W-1:0]         cut_cost;
   logic signed [pccmg_pkg::GAIN_W-1:0] move_gain;

   modport source (output valid, result_kind, cut_cost, move_gain, input ready);
   modport sink   (input valid, result_kind, cut_cost, move_gain, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pccmg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Parameterised in width and depth; no dependencies.
`default_nettype none

module pccmg_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/pccmg_clear.sv -----
// Class store write arbiter with the post-reset clearing sweep.
// Depends on pccmg_pkg.
`default_nettype none

module pccmg_clear (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pccmg_pkg::class_wr_type set_wr,
   output pccmg_pkg::class_wr_type      store_wr,
   output logic                         busy
);

   logic                           active_ff, active_in;
   logic [pccmg_pkg::VERTEX_W-1:0] addr_ff, addr_in;

   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      if (active_ff) begin
         addr_in = addr_ff + pccmg_pkg::VERTEX_W'(1);
         if (addr_ff == pccmg_pkg::VERTEX_W'(pccmg_pkg::NUM_VERTICES - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
      end
   end

   // Sweep owns the port until done; requests are held off meanwhile
   always_comb begin
      if (active_ff) begin
         store_wr.en   = 1'b1;
         store_wr.addr = addr_ff;
         store_wr.data = '0;
      end else begin
         store_wr = set_wr;
      end
   end

   assign busy = active_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/pccmg_accum.sv -----
// Accumulate stage: compares the two read classes, updates the saturating
// cut and gain sums, and holds the response register. Depends on pccmg_pkg.
`default_nettype none

module pccmg_accum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_accept,
   input  wire pccmg_pkg::stage_type          in_item,
   input  wire logic [pccmg_pkg::CLASS_W-1:0] vertex_class_rd,
   input  wire logic [pccmg_pkg::CLASS_W-1:0] neighbor_class_rd,
   output logic                               take_ready,
   pccmg_rsp_if.source                        rsp
);

   logic                             s1_valid_ff, s1_valid_in;
   pccmg_pkg::stage_type             s1_ff, s1_in;
   logic [pccmg_pkg::CUT_W-1:0]      cut_sum_ff, cut_sum_in;
   logic signed [pccmg_pkg::GAIN_W-1:0] gain_sum_ff, gain_sum_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_kind_ff, rsp_kind_in;
   logic [pccmg_pkg::CUT_W-1:0]      rsp_cut_ff, rsp_cut_in;
   logic signed [pccmg_pkg::GAIN_W-1:0] rsp_gain_ff, rsp_gain_in;

   logic                             is_cut, is_gain, emit, out_free, s1_go;
   logic [pccmg_pkg::CUT_W:0]        cut_add;
   logic [pccmg_pkg::CUT_W-1:0]      cut_next;
   logic signed [pccmg_pkg::GAIN_W:0] gain_wide;
   logic [pccmg_pkg::GAIN_W:0]       w_wide;
   logic signed [pccmg_pkg::GAIN_W-1:0] gain_next;
   logic                             same_class, to_target;

   assign is_cut   = (s1_ff.kind == pccmg_pkg::KIND_CUT);
   assign is_gain  = (s1_ff.kind == pccmg_pkg::KIND_GAIN);
   assign emit     = s1_ff.last && (is_cut || is_gain);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s1_go    = s1_valid_ff && (!emit || out_free);
   assign take_ready = !s1_valid_ff || s1_go;

   // Cut sum: add when the ends differ, pin at full scale
   always_comb begin
      cut_add  = {1'b0, cut_sum_ff}
               + {{(pccmg_pkg::CUT_W + 1 - pccmg_pkg::WEIGHT_W){1'b0}}, s1_ff.weight};
      cut_next = cut_sum_ff;
      if (vertex_class_rd != neighbor_class_rd) begin
         cut_next = cut_add[pccmg_pkg::CUT_W] ? pccmg_pkg::CUT_MAX
                                              : cut_add[pccmg_pkg::CUT_W-1:0];
      end
   end

   // Gain sum: add on same class, else subtract on target class
   always_comb begin
      same_class = (neighbor_class_rd == vertex_class_rd);
      to_target  = !same_class && (neighbor_class_rd == s1_ff.target_class);
      w_wide     = {{(pccmg_pkg::GAIN_W + 1 - pccmg_pkg::WEIGHT_W){1'b0}}, s1_ff.weight};
      gain_wide  = {gain_sum_ff[pccmg_pkg::GAIN_W-1], gain_sum_ff};
      if (same_class) begin
         gain_wide = gain_wide + $signed(w_wide);
      end else if (to_target) begin
         gain_wide = gain_wide - $signed(w_wide);
      end
      if (gain_wide[pccmg_pkg::GAIN_W] != gain_wide[pccmg_pkg::GAIN_W-1]) begin
         gain_next = gain_wide[pccmg_pkg::GAIN_W] ? pccmg_pkg::GAIN_MIN
                                                  : pccmg_pkg::GAIN_MAX;
      end else begin
         gain_next = gain_wide[pccmg_pkg::GAIN_W-1:0];
      end
   end

   always_comb begin
      s1_in       = in_accept ? in_item : s1_ff;
      s1_valid_in = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

      cut_sum_in  = cut_sum_ff;
      gain_sum_in = gain_sum_ff;
      if (s1_go && is_cut) begin
         cut_sum_in = s1_ff.last ? '0 : cut_next;
      end
      if (s1_go && is_gain) begin
         gain_sum_in = s1_ff.last ? '0 : gain_next;
      end

      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cut_in   = rsp_cut_ff;
      rsp_gain_in  = rsp_gain_ff;
      if (s1_go && emit) begin
         rsp_valid_in = 1'b1;
         if (is_cut) begin
            rsp_kind_in = pccmg_pkg::RESULT_CUT;
            rsp_cut_in  = cut_next;
            rsp_gain_in = '0;
         end else begin
            rsp_kind_in = pccmg_pkg::RESULT_GAIN;
            rsp_cut_in  = '0;
            rsp_gain_in = gain_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cut_sum_ff   <= '0;
         gain_sum_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cut_sum_ff   <= cut_sum_in;
         gain_sum_ff  <= gain_sum_in;
      end
      s1_ff       <= s1_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cut_ff  <= rsp_cut_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.cut_cost    = rsp_cut_ff;
   assign rsp.move_gain   = rsp_gain_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/partition_cut_cost_and_move_gain_top.sv -----
// Partition cut-cost and move-gain evaluator, top level.
// Holds the duplicated class store, the clearing sweep and the accumulate
// stage. Depends on pccmg_pkg, pccmg_if, pccmg_ram, pccmg_clear, pccmg_accum.
//
// Usage:
//   req_bus carries one request per handshake: a set-class write, a cut-cost
//   adjacency entry or a move-gain entry. rsp_bus returns one result for each
//   cost or gain entry marked last; other requests return nothing.
//   Throughput: one request per cycle while req_bus.ready is high. Each
//   entry needs two class reads, served by two copies of the class store
//   that are always written together. Path: the edge that takes a request
//   reads its classes and loads the accumulate stage, which for a last
//   cost or gain entry then loads the response register once it is free.
//   Reset: the accumulators clear at once; the class store is then swept to
//   zero, one entry a cycle over all 1024 entries, req_bus.ready held low.
//   Stall: a waiting result parks in the response register; one further
//   request sits in the accumulate stage, and req_bus.ready drops only when a
//   last cost or gain entry there finds the response register still full.
`default_nettype none

module partition_cut_cost_and_move_gain_top (
   input wire logic  clock,
   input wire logic  reset,
   pccmg_req_if.sink req_bus,
   pccmg_rsp_if.source rsp_bus
);

   logic                           req_accept;
   logic                           clear_busy;
   logic                           take_ready;
   pccmg_pkg::class_wr_type        set_wr;
   pccmg_pkg::class_wr_type        store_wr;
   pccmg_pkg::stage_type           item;
   logic [pccmg_pkg::CLASS_W-1:0]  vertex_class_rd;
   logic [pccmg_pkg::CLASS_W-1:0]  neighbor_class_rd;

   // Hold requests off while the store is swept or the stage is blocked
   assign req_bus.ready = !clear_busy && take_ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // Set-class writes land at the accept edge, so the next request sees them
   assign set_wr.en   = req_accept && (req_bus.kind == pccmg_pkg::KIND_SET_CLASS);
   assign set_wr.addr = req_bus.vertex;
   assign set_wr.data = pccmg_pkg::clamp_class(req_bus.vertex_class);

   // Fields that travel with the class reads; weight masked to its used bits
   assign item.kind         = req_bus.kind;
   assign item.target_class = pccmg_pkg::clamp_class(req_bus.target_class);
   assign item.weight       = req_bus.weight & pccmg_pkg::WEIGHT_MASK;
   assign item.last         = req_bus.last;

   pccmg_clear u_clear (
      .clock    (clock),
      .reset    (reset),
      .set_wr   (set_wr),
      .store_wr (store_wr),
      .busy     (clear_busy)
   );

   // Copy read at the vertex
   pccmg_ram #(
      .WIDTH (pccmg_pkg::CLASS_W),
      .DEPTH (pccmg_pkg::NUM_VERTICES)
   ) u_store_vertex (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_en   (req_accept),
      .rd_addr (req_bus.vertex),
      .rd_data (vertex_class_rd)
   );

   // Copy read at the neighbour
   pccmg_ram #(
      .WIDTH (pccmg_pkg::CLASS_W),
      .DEPTH (pccmg_pkg::NUM_VERTICES)
   ) u_store_neighbor (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_en   (req_accept),
      .rd_addr (req_bus.neighbor),
      .rd_data (neighbor_class_rd)
   );

   // Compare, accumulate and present the result
   pccmg_accum u_accum (
      .clock             (clock),
      .reset             (reset),
      .in_accept         (req_accept),
      .in_item           (item),
      .vertex_class_rd   (vertex_class_rd),
      .neighbor_class_rd (neighbor_class_rd),
      .take_ready        (take_ready),
      .rsp               (rsp_bus)
   );

endmodule

`default_nettype wire
